// ----- sv/b3pcs_pkg.sv -----
// Shared constants, types and arithmetic helpers for the base-3 product carry statistics block.
package b3pcs_pkg;

   localparam int MAX_DIGITS      = 16;
   localparam int DIGIT_W         = 2;
   localparam int VALUE_W         = 26;
   localparam int DIGIT_COUNT_W   = 5;
   localparam logic [DIGIT_COUNT_W-1:0] DIGIT_COUNT_RESET = 5'd11;
   localparam logic [DIGIT_COUNT_W-1:0] DIGIT_COUNT_MIN   = 5'd2;
   localparam logic [DIGIT_COUNT_W-1:0] DIGIT_COUNT_MAX   = DIGIT_COUNT_W'(MAX_DIGITS);

   // convolution positions 0 .. 2K-2, split into two half sums over the x digits
   localparam int CONV_LEN        = 2 * MAX_DIGITS - 1;
   localparam int HALF_DIGITS     = MAX_DIGITS / 2;
   localparam int HALF_W          = $clog2(4 * (MAX_DIGITS - HALF_DIGITS) + 1);

   // carries 0 .. 2K+2 are searched, the chain runs up to the widest K
   localparam int MAX_TOP         = 2 * MAX_DIGITS + 2;
   localparam int CARRY_W         = 6;
   localparam int POS_W           = 6;
   localparam int SUM_W           = 7;
   localparam int STEPS_PER_STAGE = 7;
   localparam int CHAIN_STAGES    = (MAX_TOP + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   localparam int PAIR_W          = 48;
   localparam int CSUM_W          = 54;
   localparam logic [PAIR_W-1:0] PAIRS_MAX = '1;
   localparam logic [CSUM_W-1:0] CSUM_MAX  = '1;

   // floor(v/3) = (v * ceil(2^27/3)) >> 27 for any 26-bit v
   localparam int DIV3_SHIFT = 27;
   localparam logic [VALUE_W-1:0] DIV3_RECIP = 26'd44739243;
   // floor(v/3) = (v * 43) >> 7 for any 7-bit v
   localparam int DIV3_SMALL_SHIFT = 7;
   localparam logic [5:0] DIV3_SMALL_RECIP = 6'd43;

   typedef logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digit_arr_type;
   typedef logic [CONV_LEN-1:0][HALF_W-1:0]    half_arr_type;
   typedef logic [MAX_TOP:0][CARRY_W-1:0]      carry_arr_type;

   typedef struct packed {
      logic valid;
      logic clear;
   } ctl_type;

   typedef struct packed {
      logic               counted;
      logic [CARRY_W-1:0] below;
      logic [POS_W-1:0]   top;
   } pair_result_type;

   function automatic logic [VALUE_W-1:0] div3_value(input logic [VALUE_W-1:0] v);
      logic [2*VALUE_W-1:0] prod;
      prod = (2*VALUE_W)'(v) * (2*VALUE_W)'(DIV3_RECIP);
      return VALUE_W'(prod[2*VALUE_W-1:DIV3_SHIFT]);
   endfunction

   function automatic logic [DIGIT_W-1:0] mod3_rest(input logic [VALUE_W-1:0] v,
                                                    input logic [VALUE_W-1:0] q);
      logic [VALUE_W-1:0] r;
      r = v - (q << 1) - q;
      return r[DIGIT_W-1:0];
   endfunction

   function automatic logic [CARRY_W-1:0] div3_small(input logic [SUM_W-1:0] v);
      logic [SUM_W+5:0] prod;
      prod = (SUM_W+6)'(v) * (SUM_W+6)'(DIV3_SMALL_RECIP);
      return prod[SUM_W+5:DIV3_SMALL_SHIFT];
   endfunction

endpackage

// ----- sv/b3pcs_digit_split.sv -----
// Pipeline that peels base-3 digits off both operands, one digit per stage.
module b3pcs_digit_split
   import b3pcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ctl_type            in_ctl,
   input  logic [VALUE_W-1:0] in_x,
   input  logic [VALUE_W-1:0] in_y,
   output ctl_type            out_ctl,
   output digit_arr_type      out_dx,
   output digit_arr_type      out_dy
);

   ctl_type            ctl_ff   [MAX_DIGITS];
   digit_arr_type      dx_ff    [MAX_DIGITS];
   digit_arr_type      dy_ff    [MAX_DIGITS];
   logic [VALUE_W-1:0] rem_x_ff [MAX_DIGITS-1];
   logic [VALUE_W-1:0] rem_y_ff [MAX_DIGITS-1];

   ctl_type            src_ctl  [MAX_DIGITS];
   digit_arr_type      src_dx   [MAX_DIGITS];
   digit_arr_type      src_dy   [MAX_DIGITS];
   logic [VALUE_W-1:0] src_x    [MAX_DIGITS];
   logic [VALUE_W-1:0] src_y    [MAX_DIGITS];
   digit_arr_type      dx_in    [MAX_DIGITS];
   digit_arr_type      dy_in    [MAX_DIGITS];
   logic [VALUE_W-1:0] rem_x_in [MAX_DIGITS];
   logic [VALUE_W-1:0] rem_y_in [MAX_DIGITS];

   always_comb begin
      src_ctl[0] = in_ctl;
      src_x[0]   = in_x;
      src_y[0]   = in_y;
      src_dx[0]  = '0;
      src_dy[0]  = '0;
      for (int s = 1; s < MAX_DIGITS; s++) begin
         src_ctl[s] = ctl_ff[s-1];
         src_x[s]   = rem_x_ff[s-1];
         src_y[s]   = rem_y_ff[s-1];
         src_dx[s]  = dx_ff[s-1];
         src_dy[s]  = dy_ff[s-1];
      end
      // stage s produces digit s; the quotient moves on to the next stage
      for (int s = 0; s < MAX_DIGITS; s++) begin
         rem_x_in[s] = div3_value(src_x[s]);
         rem_y_in[s] = div3_value(src_y[s]);
         dx_in[s]    = src_dx[s];
         dy_in[s]    = src_dy[s];
         dx_in[s][s] = mod3_rest(src_x[s], rem_x_in[s]);
         dy_in[s][s] = mod3_rest(src_y[s], rem_y_in[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAX_DIGITS; s++) ctl_ff[s] <= '0;
      end else if (advance) begin
         for (int s = 0; s < MAX_DIGITS; s++) ctl_ff[s] <= src_ctl[s];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < MAX_DIGITS; s++) begin
            dx_ff[s] <= dx_in[s];
            dy_ff[s] <= dy_in[s];
         end
         for (int s = 0; s < MAX_DIGITS - 1; s++) begin
            rem_x_ff[s] <= rem_x_in[s];
            rem_y_ff[s] <= rem_y_in[s];
         end
      end
   end

   assign out_ctl = ctl_ff[MAX_DIGITS-1];
   assign out_dx  = dx_ff[MAX_DIGITS-1];
   assign out_dy  = dy_ff[MAX_DIGITS-1];

endmodule

// ----- sv/b3pcs_carry_chain.sv -----
// Digit convolution, staged base-3 carry chain and top-carry search.
module b3pcs_carry_chain
   import b3pcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic [DIGIT_COUNT_W-1:0] digit_k,
   input  ctl_type                  in_ctl,
   input  digit_arr_type            in_dx,
   input  digit_arr_type            in_dy,
   output ctl_type                  out_ctl,
   output pair_result_type          out_res
);

   // convolution stage
   ctl_type         conv_ctl_ff;
   half_arr_type    lo_ff;
   half_arr_type    hi_ff;
   half_arr_type    lo_in;
   half_arr_type    hi_in;
   digit_arr_type   dx_m;
   digit_arr_type   dy_m;

   // chain stages
   ctl_type         chain_ctl_ff [CHAIN_STAGES];
   carry_arr_type   carry_ff     [CHAIN_STAGES];
   half_arr_type    chain_lo_ff  [CHAIN_STAGES-1];
   half_arr_type    chain_hi_ff  [CHAIN_STAGES-1];
   ctl_type         src_ctl      [CHAIN_STAGES];
   carry_arr_type   src_carry    [CHAIN_STAGES];
   half_arr_type    src_lo       [CHAIN_STAGES];
   half_arr_type    src_hi       [CHAIN_STAGES];
   carry_arr_type   carry_in     [CHAIN_STAGES];

   // search stage
   ctl_type         res_ctl_ff;
   pair_result_type res_ff;
   pair_result_type res_in;

   always_comb begin
      logic [2:0] prod;
      lo_in = '0;
      hi_in = '0;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         dx_m[i] = (DIGIT_COUNT_W'(i) < digit_k) ? in_dx[i] : '0;
         dy_m[i] = (DIGIT_COUNT_W'(i) < digit_k) ? in_dy[i] : '0;
      end
      // each position gathers at most eight terms per half
      for (int i = 0; i < MAX_DIGITS; i++) begin
         for (int j = 0; j < MAX_DIGITS; j++) begin
            prod = 3'(dx_m[i]) * 3'(dy_m[j]);
            if (i < HALF_DIGITS) lo_in[i+j] = lo_in[i+j] + HALF_W'(prod);
            else                 hi_in[i+j] = hi_in[i+j] + HALF_W'(prod);
         end
      end
   end

   always_comb begin
      logic [SUM_W-1:0] acc;
      int p;
      src_ctl[0]   = conv_ctl_ff;
      src_carry[0] = '0;
      src_lo[0]    = lo_ff;
      src_hi[0]    = hi_ff;
      for (int c = 1; c < CHAIN_STAGES; c++) begin
         src_ctl[c]   = chain_ctl_ff[c-1];
         src_carry[c] = carry_ff[c-1];
         src_lo[c]    = chain_lo_ff[c-1];
         src_hi[c]    = chain_hi_ff[c-1];
      end
      // positions past the convolution just keep dividing the carry by 3
      for (int c = 0; c < CHAIN_STAGES; c++) begin
         carry_in[c] = src_carry[c];
         for (int t = 0; t < STEPS_PER_STAGE; t++) begin
            p = c * STEPS_PER_STAGE + t;
            if (p < MAX_TOP) begin
               acc = SUM_W'(carry_in[c][p]);
               if (p < CONV_LEN) begin
                  acc = acc + SUM_W'(src_lo[c][p]) + SUM_W'(src_hi[c][p]);
               end
               carry_in[c][p+1] = div3_small(acc);
            end
         end
      end
   end

   // highest nonzero carry; the carry above it is zero by construction,
   // since the first carry past position 2K+2 is at most 1/3 and so zero
   always_comb begin
      res_in = '0;
      for (int p = 1; p <= MAX_TOP; p++) begin
         if (carry_ff[CHAIN_STAGES-1][p] != '0) begin
            res_in.top   = POS_W'(p);
            res_in.below = carry_ff[CHAIN_STAGES-1][p-1];
         end
      end
      res_in.counted = (res_in.top != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ctl_ff <= '0;
         for (int c = 0; c < CHAIN_STAGES; c++) chain_ctl_ff[c] <= '0;
         res_ctl_ff  <= '0;
      end else if (advance) begin
         conv_ctl_ff <= in_ctl;
         for (int c = 0; c < CHAIN_STAGES; c++) chain_ctl_ff[c] <= src_ctl[c];
         res_ctl_ff  <= chain_ctl_ff[CHAIN_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         for (int c = 0; c < CHAIN_STAGES; c++) carry_ff[c] <= carry_in[c];
         for (int c = 0; c < CHAIN_STAGES - 1; c++) begin
            chain_lo_ff[c] <= src_lo[c];
            chain_hi_ff[c] <= src_hi[c];
         end
         res_ff <= res_in;
      end
   end

   assign out_ctl = res_ctl_ff;
   assign out_res = res_ff;

endmodule

// ----- sv/b3pcs_totals.sv -----
// Output register with the saturating pair count and carry sum.
module b3pcs_totals
   import b3pcs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ctl_type             in_ctl,
   input  pair_result_type     in_res,
   output logic                out_valid,
   output logic                out_counted,
   output logic [CARRY_W-1:0]  out_below,
   output logic [POS_W-1:0]    out_top,
   output logic [PAIR_W-1:0]   out_pair_total,
   output logic [CSUM_W-1:0]   out_carry_sum
);

   logic                valid_ff;
   pair_result_type     res_ff;
   logic [PAIR_W-1:0]   pair_total_ff;
   logic [PAIR_W-1:0]   pair_total_in;
   logic [CSUM_W-1:0]   carry_sum_ff;
   logic [CSUM_W-1:0]   carry_sum_in;
   logic                take;

   assign take = advance && in_ctl.valid;

   always_comb begin
      logic [PAIR_W:0]   pair_next;
      logic [CSUM_W:0]   sum_next;
      logic [PAIR_W-1:0] pair_base;
      logic [CSUM_W-1:0] sum_base;
      pair_base = in_ctl.clear ? '0 : pair_total_ff;
      sum_base  = in_ctl.clear ? '0 : carry_sum_ff;
      pair_next = {1'b0, pair_base} + (PAIR_W+1)'(1);
      sum_next  = {1'b0, sum_base} + (CSUM_W+1)'(in_res.below);
      pair_total_in = pair_base;
      carry_sum_in  = sum_base;
      if (in_res.counted) begin
         // a carry out of the top bit means the total hit its ceiling
         pair_total_in = pair_next[PAIR_W] ? PAIRS_MAX : pair_next[PAIR_W-1:0];
         carry_sum_in  = sum_next[CSUM_W]  ? CSUM_MAX  : sum_next[CSUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         pair_total_ff <= '0;
         carry_sum_ff  <= '0;
      end else begin
         if (advance) valid_ff <= in_ctl.valid;
         if (take) begin
            pair_total_ff <= pair_total_in;
            carry_sum_ff  <= carry_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) res_ff <= in_res;
   end

   assign out_valid      = valid_ff;
   assign out_counted    = res_ff.counted;
   assign out_below      = res_ff.below;
   assign out_top        = res_ff.top;
   assign out_pair_total = pair_total_ff;
   assign out_carry_sum  = carry_sum_ff;

`ifndef SYNTHESIS
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (take && !in_ctl.clear && in_res.counted && pair_total_ff != PAIRS_MAX)
      |=> pair_total_ff == $past(pair_total_ff) + PAIR_W'(1))
      else $error("pair count did not step by one on a counted item");
   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(pair_total_ff) && $stable(carry_sum_ff))
      else $error("totals moved without an item");
   a_hold_uncounted: assert property (@(posedge clock) disable iff (reset)
      (take && !in_ctl.clear && !in_res.counted)
      |=> $stable(pair_total_ff) && $stable(carry_sum_ff))
      else $error("totals moved on an uncounted item");
   a_sum_grows: assert property (@(posedge clock) disable iff (reset)
      (take && !in_ctl.clear) |=> carry_sum_ff >= $past(carry_sum_ff))
      else $error("carry sum went down without a clear");
`endif

endmodule

// ----- sv/base3_product_top_carry_stats.sv -----
// Base-3 product carry statistics: one pair per cycle unless the pipeline holds; a pair
// passes through 16 digit-extraction stages (one base-3 digit of each operand per stage),
// one convolution stage, 5 carry-chain stages of up to 7 carry steps each, one top-carry
// search stage and the output register. The whole pipeline holds while a result waits to be
// taken, so req_ready follows rsp_ready whenever the output register is full. digit_count is
// taken as 2 below 2 and as 16 above 16; write it only while no item is in flight.
module base3_product_top_carry_stats
   import b3pcs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [VALUE_W-1:0]       req_x_value,
   input  logic [VALUE_W-1:0]       req_y_value,
   input  logic                     req_clear_totals,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_pair_counted,
   output logic [CARRY_W-1:0]       rsp_carry_below_top,
   output logic [POS_W-1:0]         rsp_top_position,
   output logic [PAIR_W-1:0]        rsp_pair_total,
   output logic [CSUM_W-1:0]        rsp_carry_sum_total,
   input  logic                     csr_wr_en,
   input  logic [DIGIT_COUNT_W-1:0] csr_wr_data
);

   logic [DIGIT_COUNT_W-1:0] digit_count_ff;
   logic [DIGIT_COUNT_W-1:0] digit_k;
   logic                     advance;
   ctl_type                  req_ctl;
   ctl_type                  split_ctl;
   ctl_type                  chain_ctl;
   digit_arr_type            split_dx;
   digit_arr_type            split_dy;
   pair_result_type          chain_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_count_ff <= DIGIT_COUNT_RESET;
      end else if (csr_wr_en) begin
         digit_count_ff <= csr_wr_data;
      end
   end

   always_comb begin
      digit_k = digit_count_ff;
      if (digit_count_ff < DIGIT_COUNT_MIN) digit_k = DIGIT_COUNT_MIN;
      if (digit_count_ff > DIGIT_COUNT_MAX) digit_k = DIGIT_COUNT_MAX;
   end

   assign advance       = !rsp_valid || rsp_ready;
   assign req_ready     = advance;
   assign req_ctl.valid = req_valid;
   assign req_ctl.clear = req_clear_totals;

   b3pcs_digit_split u_split (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (req_ctl),
      .in_x    (req_x_value),
      .in_y    (req_y_value),
      .out_ctl (split_ctl),
      .out_dx  (split_dx),
      .out_dy  (split_dy)
   );

   b3pcs_carry_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .digit_k (digit_k),
      .in_ctl  (split_ctl),
      .in_dx   (split_dx),
      .in_dy   (split_dy),
      .out_ctl (chain_ctl),
      .out_res (chain_res)
   );

   b3pcs_totals u_totals (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_ctl         (chain_ctl),
      .in_res         (chain_res),
      .out_valid      (rsp_valid),
      .out_counted    (rsp_pair_counted),
      .out_below      (rsp_carry_below_top),
      .out_top        (rsp_top_position),
      .out_pair_total (rsp_pair_total),
      .out_carry_sum  (rsp_carry_sum_total)
   );

endmodule
